@@ hw/rtl/pal_pkg.sv @@
// pal_pkg: shared constants, opcodes, status codes and types for the
// positional array list. No dependencies; imported by every module.
package pal_pkg;

	// Fixed field widths of the request/result ports
	localparam int OPC_W  = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 9;

	// Default build
	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OPC_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OPC_W-1:0] OP_SET    = 3'd2;
	localparam logic [OPC_W-1:0] OP_GET    = 3'd3;
	localparam logic [OPC_W-1:0] OP_LOCATE = 3'd4;

	// Result status
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic apply; // commit the update this cycle
		logic ins;   // legal insert
		logic del;   // legal delete
		logic set;   // legal set
		logic rd;    // flag the cell at the position (get/delete)
		logic loc;   // flag cells matching the search word
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} st_t;

endpackage

@@ hw/rtl/pal_cell.sv @@
// pal_cell: one storage cell of the list row; holds one word and shifts
// with its neighbours. Depends on pal_pkg.
module pal_cell #(
	parameter int DW  = 32,
	parameter int IDX = 0,
	parameter int PW  = 8,
	parameter int CW  = 9
) (
	input  logic            clk,
	input  pal_pkg::cmd_t   cmd,
	input  logic [DW-1:0]   left_word,
	input  logic [DW-1:0]   right_word,
	input  logic [DW-1:0]   value,
	input  logic [PW-1:0]   pos,
	input  logic [CW-1:0]   count,
	output logic [DW-1:0]   word,
	output logic            hit
);
	import pal_pkg::*;

	localparam logic [PW-1:0] MY_POS = PW'(IDX);
	localparam logic [CW-1:0] MY_CNT = CW'(IDX);

	logic [DW-1:0] word_q;
	logic          at_pos;
	logic          above;
	logic          in_list;

	assign at_pos  = (pos == MY_POS);
	assign above   = (pos < MY_POS);
	assign in_list = (MY_CNT < count);

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (cmd.ins && above) begin
				word_q <= left_word;
			end else if ((cmd.ins || cmd.set) && at_pos) begin
				word_q <= value;
			end else if (cmd.del && (above || at_pos)) begin
				word_q <= right_word;
			end
		end
	end

	assign word = word_q;
	assign hit  = (cmd.rd && at_pos) || (cmd.loc && in_list && (word_q == value));

endmodule

@@ hw/rtl/pal_tree.sv @@
// pal_tree: registered binary priority tree, lowest flagged leaf wins,
// one level per cycle. Depends on pal_pkg.
module pal_tree #(
	parameter int NP = 256,
	parameter int IW = 8,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [NP-1:0] leaf_hit,
	input  logic [DW-1:0] leaf_data [NP],
	output logic          root_hit,
	output logic [IW-1:0] root_idx,
	output logic [DW-1:0] root_data
);
	import pal_pkg::*;

	logic          node_hit_q  [1:NP-1];
	logic [IW-1:0] node_idx_q  [1:NP-1];
	logic [DW-1:0] node_data_q [1:NP-1];

	genvar n;
	generate
		for (n = 1; n < NP; n++) begin : g_node
			logic          lh, rh;
			logic [IW-1:0] li, ri;
			logic [DW-1:0] ld, rdat;
			if (2 * n >= NP) begin : g_leaf
				assign lh   = leaf_hit[2*n-NP];
				assign rh   = leaf_hit[2*n+1-NP];
				assign li   = IW'(2*n-NP);
				assign ri   = IW'(2*n+1-NP);
				assign ld   = leaf_data[2*n-NP];
				assign rdat = leaf_data[2*n+1-NP];
			end else begin : g_inner
				assign lh   = node_hit_q[2*n];
				assign rh   = node_hit_q[2*n+1];
				assign li   = node_idx_q[2*n];
				assign ri   = node_idx_q[2*n+1];
				assign ld   = node_data_q[2*n];
				assign rdat = node_data_q[2*n+1];
			end
			// left child has priority: it holds the lower positions
			always_ff @(posedge clk) begin
				node_hit_q[n]  <= lh | rh;
				node_idx_q[n]  <= lh ? li : ri;
				node_data_q[n] <= lh ? ld : rdat;
			end
		end
	endgenerate

	assign root_hit  = node_hit_q[1];
	assign root_idx  = node_idx_q[1];
	assign root_data = node_data_q[1];

endmodule

@@ hw/rtl/positional_array_list_core.sv @@
// positional_array_list_core: top level of the positional array list.
// Depends on pal_pkg, pal_cell and pal_tree.
//
// Usage
//   Requests enter on the in_ channel (opcode, position, value) and each
//   gives exactly one result on the out_ channel. A request is taken when
//   in_valid is high and in_stall low; a result is taken likewise on the
//   out_ side. One request is in flight at a time: in_stall stays high
//   from acceptance until its result has been loaded into the output
//   register.
//   Reads and matches are gathered from the row of cells by the registered
//   priority tree, one tree level per cycle.
//   The list update (shift up, shift down, overwrite) happens in every cell
//   at once, in the cycle the result is loaded.
//   If the receiver stalls, the result register holds its value and the
//   next finished request waits with the list unchanged until it frees.
//   Reset empties the list (length 0); stored words are left as they are
//   and are never visible since only positions below the length are read.
module positional_array_list_core #(
	parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pal_pkg::OPC_W-1:0]  opcode,
	input  logic [pal_pkg::POS_W-1:0]  position,
	input  logic [pal_pkg::VAL_W-1:0]  value,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pal_pkg::VAL_W-1:0]  read_value,
	output logic                       found,
	output logic [pal_pkg::POS_W-1:0]  found_index,
	output logic [pal_pkg::STAT_W-1:0] status,
	output logic [pal_pkg::LEN_W-1:0]  list_length,
	output logic                       is_empty
);
	import pal_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int MW   = (DW < VAL_W) ? DW : VAL_W;   // bits carried by the ports
	localparam int CW   = $clog2(CAPACITY + 1);        // entry count width
	localparam int IW   = $clog2(CAPACITY);            // position index width
	localparam int NP   = 1 << IW;                     // tree leaves
	localparam int LVLS = IW;                          // tree depth
	localparam int CNTW = $clog2(LVLS + 1);
	localparam int PW   = (IW > POS_W) ? IW : POS_W;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// control
	st_t             state_q, state_nxt;
	logic [CNTW-1:0] lvl_q;
	logic            out_valid_q;
	logic [CW-1:0]   count_q;
	logic            in_take;
	logic            finish;

	// request held while it is worked on
	logic [OPC_W-1:0] req_op_q;
	logic [POS_W-1:0] req_pos_q;
	logic [DW-1:0]    req_val_q;

	// result register
	logic [VAL_W-1:0]  rd_q;
	logic              found_q;
	logic [POS_W-1:0]  idx_q;
	logic [STAT_W-1:0] stat_q;
	logic [LEN_W-1:0]  len_q;
	logic              empty_q;

	// datapath
	logic [STAT_W-1:0] stat_c;
	logic              ok_c;
	logic [CMPW-1:0]   pos_c;
	logic [CMPW-1:0]   cnt_c;
	logic [CW-1:0]     count_nxt;
	cmd_t              cmd;
	logic [PW-1:0]     cell_pos;
	logic [DW-1:0]     cell_word [CAPACITY];
	logic [NP-1:0]     leaf_hit;
	logic [DW-1:0]     leaf_data [NP];
	logic              root_hit;
	logic [IW-1:0]     root_idx;
	logic [DW-1:0]     root_data;

	assign in_take = in_valid && !in_stall;
	assign finish  = (state_q == ST_WORK) && (lvl_q == CNTW'(LVLS))
	                 && (!out_valid_q || !out_stall);

	// ---- state machine ----
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_WORK;
				end
			end
			ST_WORK: begin
				if (finish) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_WORK: in_stall = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_take) begin
				lvl_q <= '0;
			end else if ((state_q == ST_WORK) && (lvl_q != CNTW'(LVLS))) begin
				lvl_q <= lvl_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_op_q  <= opcode;
			req_pos_q <= position;
			req_val_q <= DW'(value[MW-1:0]);
		end
	end

	// ---- status and new length ----
	assign pos_c = CMPW'(req_pos_q);
	assign cnt_c = CMPW'(count_q);

	always_comb begin
		stat_c = STAT_OK;
		case (req_op_q)
			OP_INSERT: begin
				if (pos_c > cnt_c) begin
					stat_c = STAT_ILLEGAL;
				end else if (cnt_c == CMPW'(CAPACITY)) begin
					stat_c = STAT_FULL;
				end
			end
			OP_DELETE, OP_SET, OP_GET: begin
				if (pos_c >= cnt_c) begin
					stat_c = STAT_ILLEGAL;
				end
			end
			default: stat_c = STAT_OK;
		endcase
	end

	assign ok_c = (stat_c == STAT_OK);

	always_comb begin
		cmd       = '0;
		cmd.apply = finish;
		cmd.ins   = ok_c && (req_op_q == OP_INSERT);
		cmd.del   = ok_c && (req_op_q == OP_DELETE);
		cmd.set   = ok_c && (req_op_q == OP_SET);
		cmd.rd    = (req_op_q == OP_GET) || (req_op_q == OP_DELETE);
		cmd.loc   = (req_op_q == OP_LOCATE);
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (cmd.del) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// ---- row of cells ----
	assign cell_pos = PW'(req_pos_q);

	genvar i;
	generate
		for (i = 0; i < NP; i++) begin : g_row
			if (i < CAPACITY) begin : g_cell
				logic [DW-1:0] lw, rw;
				if (i == 0) begin : g_first
					assign lw = '0;
				end else begin : g_left
					assign lw = cell_word[i-1];
				end
				if (i == CAPACITY - 1) begin : g_last
					assign rw = '0;
				end else begin : g_right
					assign rw = cell_word[i+1];
				end
				pal_cell #(
					.DW  (DW),
					.IDX (i),
					.PW  (PW),
					.CW  (CW)
				) u_cell (
					.clk        (clk),
					.cmd        (cmd),
					.left_word  (lw),
					.right_word (rw),
					.value      (req_val_q),
					.pos        (cell_pos),
					.count      (count_q),
					.word       (cell_word[i]),
					.hit        (leaf_hit[i])
				);
				assign leaf_data[i] = cell_word[i];
			end else begin : g_pad
				assign leaf_hit[i]  = 1'b0;
				assign leaf_data[i] = '0;
			end
		end
	endgenerate

	// ---- read / match gather ----
	pal_tree #(
		.NP (NP),
		.IW (IW),
		.DW (DW)
	) u_tree (
		.clk       (clk),
		.leaf_hit  (leaf_hit),
		.leaf_data (leaf_data),
		.root_hit  (root_hit),
		.root_idx  (root_idx),
		.root_data (root_data)
	);

	// ---- result register ----
	always_ff @(posedge clk) begin
		if (finish) begin
			rd_q    <= (cmd.rd && ok_c) ? VAL_W'(root_data[MW-1:0]) : '0;
			found_q <= cmd.loc && root_hit;
			idx_q   <= (cmd.loc && root_hit) ? POS_W'(root_idx) : '0;
			stat_q  <= stat_c;
			len_q   <= LEN_W'(count_nxt);
			empty_q <= (count_nxt == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = rd_q;
	assign found       = found_q;
	assign found_index = idx_q;
	assign status      = stat_q;
	assign list_length = len_q;
	assign is_empty    = empty_q;

endmodule

@@ hw/rtl/pal_checker.sv @@
// pal_checker: port-level checks for positional_array_list_core, bound
// to the top level below. Depends on pal_pkg.
module pal_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [pal_pkg::VAL_W-1:0]  read_value,
	input logic                       found,
	input logic [pal_pkg::STAT_W-1:0] status,
	input logic                       is_empty
);
	import pal_pkg::*;

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one request in flight: the next cycle after a request is taken is busy
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// a locate hit carries no read word and an ok status
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (status == STAT_OK) && (read_value == '0))
		else $error("locate hit with read word or error status");

	// a full status comes with a non-empty list and no locate hit
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FULL) |-> !is_empty && !found)
		else $error("full status on empty list");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_value (read_value),
	.found      (found),
	.status     (status),
	.is_empty   (is_empty)
);
